// ----- hw/rtl/bbdq_pkg.sv -----
// shared types, codes and reset values for the byte budget drop queue
package bbdq_pkg;

	// field widths fixed by the stream format
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned TAG_W    = 16;
	localparam int unsigned SIZE_W   = 32;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned REASON_W = 2;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned BUDGET_W = 40;
	localparam int unsigned SUM_W    = BUDGET_W + 1;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned S_DATA_W = 48;
	localparam int unsigned M_DATA_W = 64;

	// input item modes
	localparam logic [MODE_W-1:0] MODE_ENQUEUE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COLLECT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EVICTED   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BATCH_REC = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BATCH_NIL = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SHUT      = 3'd5;
	localparam logic [KIND_W-1:0] KIND_WAS_SHUT  = 3'd6;

	// drop reasons
	localparam logic [REASON_W-1:0] REASON_NONE  = 2'd0;
	localparam logic [REASON_W-1:0] REASON_SHUT  = 2'd1;
	localparam logic [REASON_W-1:0] REASON_LARGE = 2'd2;
	localparam logic [REASON_W-1:0] REASON_FULL  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REC_SZ  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EVICT_OLD   = 3'd4;

	// configuration reset values
	localparam logic [COUNT_W-1:0]  RST_MAX_RECORDS = 6'd32;
	localparam logic [COUNT_W-1:0]  RST_BATCH_SIZE  = 6'd16;
	localparam logic [SIZE_W-1:0]   RST_MAX_REC_SZ  = 32'd65536;
	localparam logic [BUDGET_W-1:0] RST_MAX_BYTES   = 40'd16777216;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_POP
	} state_t;

	// per-cycle control from the sequencer
	typedef struct packed {
		logic                emit;
		logic [KIND_W-1:0]   kind;
		logic                from_ram;
		logic [REASON_W-1:0] reason;
		logic                ready;
		logic                done;
		logic                last;
		logic                push;
		logic                pop;
		logic                rd_en;
		logic                load_rem;
		logic                set_shut;
	} ctl_t;

endpackage

// ----- hw/rtl/bbdq_ram.sv -----
// generic simple dual port ram with registered read
module bbdq_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/byte_budget_drop_queue.sv -----
// byte budget drop queue: bounded record fifo with count and byte caps
// An input item is taken only when the sequencer is idle. Enqueue and shutdown
// items pass a transfer (S_IDLE) and a decision (S_DECIDE), a refused record likewise.
// Under evict-oldest each evicted record adds a ram read of the head entry in S_DECIDE,
// then its result in S_POP, after which the byte and count caps are checked again in
// S_DECIDE. A collect of n records reads the first head in S_DECIDE and gives each record
// in S_POP, the ram read of the next head overlapping the result of the current one. A
// stalled result port holds the sequencer in S_DECIDE or S_POP; the result register lets
// the last result of an item wait while the next item is taken in.
module byte_budget_drop_queue #(
	parameter int unsigned QUEUE_DEPTH = 32,
	parameter int unsigned TAG_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bbdq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bbdq_pkg::BUDGET_W-1:0]     cfg_data,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bbdq_pkg::S_DATA_W-1:0]     s_tdata,  // record_tag[15:0], record_size[47:16]
	input  logic [bbdq_pkg::MODE_W-1:0]       s_tuser,  // mode[1:0]
	// results
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bbdq_pkg::M_DATA_W-1:0]     m_tdata,  // tag[15:0], size[47:16], drop_reason[49:48],
	                                                    // batch_ready[50], queue_count[56:51],
	                                                    // done_res[57], zero[63:58]
	output logic [bbdq_pkg::KIND_W-1:0]       m_tuser,  // kind[2:0]
	output logic                              m_tlast
);

	localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int unsigned STAG_W  = (TAG_BITS < bbdq_pkg::TAG_W) ? TAG_BITS : bbdq_pkg::TAG_W;
	localparam int unsigned BYTES_W = bbdq_pkg::SIZE_W + $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned RAM_W   = STAG_W + bbdq_pkg::SIZE_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [bbdq_pkg::COUNT_W-1:0] DEPTH_CNT = bbdq_pkg::COUNT_W'(QUEUE_DEPTH);

	// configuration registers
	logic [bbdq_pkg::COUNT_W-1:0]  max_records_q;
	logic [bbdq_pkg::COUNT_W-1:0]  batch_size_q;
	logic [bbdq_pkg::SIZE_W-1:0]   max_rec_sz_q;
	logic [bbdq_pkg::BUDGET_W-1:0] max_bytes_q;
	logic                          evict_old_q;

	// queue state
	logic [IDX_W-1:0]             head_q;
	logic [IDX_W-1:0]             tail_q;
	logic [bbdq_pkg::COUNT_W-1:0] count_q;
	logic [BYTES_W-1:0]           bytes_q;
	logic                         shut_q;

	// item registers
	bbdq_pkg::state_t             state_q;
	bbdq_pkg::state_t             state_nxt;
	logic [bbdq_pkg::MODE_W-1:0]  mode_q;
	logic [STAG_W-1:0]            tag_q;
	logic [bbdq_pkg::SIZE_W-1:0]  size_q;
	logic [bbdq_pkg::COUNT_W-1:0] rem_q;
	logic                         done_q;

	// result register
	logic                          out_valid_q;
	logic [bbdq_pkg::KIND_W-1:0]   out_kind_q;
	logic [bbdq_pkg::TAG_W-1:0]    out_tag_q;
	logic [bbdq_pkg::SIZE_W-1:0]   out_size_q;
	logic [bbdq_pkg::REASON_W-1:0] out_reason_q;
	logic                          out_ready_q;
	logic [bbdq_pkg::COUNT_W-1:0]  out_count_q;
	logic                          out_done_q;
	logic                          out_last_q;

	// datapath signals
	bbdq_pkg::ctl_t               ctl;
	logic                         out_free;
	logic [bbdq_pkg::COUNT_W-1:0] cap;
	logic [bbdq_pkg::SUM_W-1:0]   bytes_sum;
	logic                         over_cap;
	logic                         too_large;
	logic                         collect_done;
	logic                         collect_none;
	logic [IDX_W-1:0]             head_inc;
	logic [IDX_W-1:0]             tail_inc;
	logic [IDX_W-1:0]             rd_addr;
	logic [RAM_W-1:0]             rd_data;
	logic [STAG_W-1:0]            rd_tag;
	logic [bbdq_pkg::SIZE_W-1:0]  rd_size;
	logic [bbdq_pkg::COUNT_W-1:0] count_nxt;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == bbdq_pkg::S_IDLE);
	assign out_free  = !out_valid_q || m_tready;

	// admission checks, one shared add and compare for the byte budget
	assign cap       = (max_records_q < DEPTH_CNT) ? max_records_q : DEPTH_CNT;
	assign bytes_sum = bbdq_pkg::SUM_W'(bytes_q) + bbdq_pkg::SUM_W'(size_q);
	assign over_cap  = (count_q >= cap) || (bytes_sum > bbdq_pkg::SUM_W'(max_bytes_q));
	assign too_large = size_q > max_rec_sz_q;

	// collect bookkeeping
	assign collect_none = (count_q == '0) || (batch_size_q == '0);
	assign collect_done = shut_q && (count_q <= batch_size_q);

	// ring pointers
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign rd_addr  = (state_q == bbdq_pkg::S_POP) ? head_inc : head_q;
	assign rd_tag   = rd_data[RAM_W-1:bbdq_pkg::SIZE_W];
	assign rd_size  = rd_data[bbdq_pkg::SIZE_W-1:0];

	bbdq_ram #(
		.WIDTH (RAM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (ctl.push),
		.wr_addr (tail_q),
		.wr_data ({tag_q, size_q}),
		.rd_en   (ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			bbdq_pkg::S_DECIDE: begin
				if (out_free) begin
					case (mode_q)
						bbdq_pkg::MODE_ENQUEUE: begin
							if (shut_q) begin
								ctl.emit   = 1'b1;
								ctl.kind   = bbdq_pkg::KIND_DROPPED;
								ctl.reason = bbdq_pkg::REASON_SHUT;
								ctl.last   = 1'b1;
							end else if (too_large) begin
								ctl.emit   = 1'b1;
								ctl.kind   = bbdq_pkg::KIND_DROPPED;
								ctl.reason = bbdq_pkg::REASON_LARGE;
								ctl.last   = 1'b1;
							end else if (over_cap) begin
								if (!evict_old_q || count_q == '0) begin
									ctl.emit   = 1'b1;
									ctl.kind   = bbdq_pkg::KIND_DROPPED;
									ctl.reason = bbdq_pkg::REASON_FULL;
									ctl.last   = 1'b1;
								end else begin
									ctl.rd_en = 1'b1;
								end
							end else begin
								ctl.emit  = 1'b1;
								ctl.kind  = bbdq_pkg::KIND_ACCEPTED;
								ctl.push  = 1'b1;
								ctl.ready = (count_q + 1'b1) >= batch_size_q;
								ctl.last  = 1'b1;
							end
						end
						bbdq_pkg::MODE_COLLECT: begin
							if (collect_none) begin
								ctl.emit = 1'b1;
								ctl.kind = bbdq_pkg::KIND_BATCH_NIL;
								ctl.done = collect_done;
								ctl.last = 1'b1;
							end else begin
								ctl.rd_en    = 1'b1;
								ctl.load_rem = 1'b1;
							end
						end
						bbdq_pkg::MODE_SHUTDOWN: begin
							ctl.emit     = 1'b1;
							ctl.kind     = shut_q ? bbdq_pkg::KIND_WAS_SHUT : bbdq_pkg::KIND_SHUT;
							ctl.set_shut = 1'b1;
							ctl.last     = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			bbdq_pkg::S_POP: begin
				if (out_free) begin
					ctl.emit     = 1'b1;
					ctl.pop      = 1'b1;
					ctl.from_ram = 1'b1;
					if (mode_q == bbdq_pkg::MODE_ENQUEUE) begin
						ctl.kind   = bbdq_pkg::KIND_EVICTED;
						ctl.reason = bbdq_pkg::REASON_FULL;
					end else begin
						ctl.kind  = bbdq_pkg::KIND_BATCH_REC;
						ctl.done  = done_q;
						ctl.last  = (rem_q == bbdq_pkg::COUNT_W'(1));
						ctl.rd_en = (rem_q != bbdq_pkg::COUNT_W'(1));
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bbdq_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_nxt = bbdq_pkg::S_DECIDE;
				end
			end
			bbdq_pkg::S_DECIDE: begin
				if (ctl.rd_en) begin
					state_nxt = bbdq_pkg::S_POP;
				end else if (ctl.emit || mode_q == bbdq_pkg::MODE_RESERVED) begin
					state_nxt = bbdq_pkg::S_IDLE;
				end
			end
			bbdq_pkg::S_POP: begin
				if (ctl.emit) begin
					if (ctl.rd_en) begin
						state_nxt = bbdq_pkg::S_POP;
					end else if (mode_q == bbdq_pkg::MODE_ENQUEUE) begin
						state_nxt = bbdq_pkg::S_DECIDE;
					end else begin
						state_nxt = bbdq_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = bbdq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbdq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_records_q <= bbdq_pkg::RST_MAX_RECORDS;
			batch_size_q  <= bbdq_pkg::RST_BATCH_SIZE;
			max_rec_sz_q  <= bbdq_pkg::RST_MAX_REC_SZ;
			max_bytes_q   <= bbdq_pkg::RST_MAX_BYTES;
			evict_old_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bbdq_pkg::CFG_MAX_RECORDS: max_records_q <= cfg_data[bbdq_pkg::COUNT_W-1:0];
				bbdq_pkg::CFG_BATCH_SIZE:  batch_size_q  <= cfg_data[bbdq_pkg::COUNT_W-1:0];
				bbdq_pkg::CFG_MAX_REC_SZ:  max_rec_sz_q  <= cfg_data[bbdq_pkg::SIZE_W-1:0];
				bbdq_pkg::CFG_MAX_BYTES:   max_bytes_q   <= cfg_data;
				bbdq_pkg::CFG_EVICT_OLD:   evict_old_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q <= s_tuser;
			tag_q  <= s_tdata[STAG_W-1:0];
			size_q <= s_tdata[bbdq_pkg::TAG_W +: bbdq_pkg::SIZE_W];
		end
		if (ctl.load_rem) begin
			done_q <= collect_done;
		end
	end

	// queue occupancy after this cycle
	always_comb begin
		count_nxt = count_q;
		if (ctl.push) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.pop) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// ring pointers, counters and shutdown flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			bytes_q <= '0;
			shut_q  <= 1'b0;
			rem_q   <= '0;
		end else begin
			count_q <= count_nxt;
			if (ctl.push) begin
				tail_q  <= tail_inc;
				bytes_q <= bytes_q + BYTES_W'(size_q);
			end else if (ctl.pop) begin
				head_q  <= head_inc;
				bytes_q <= bytes_q - BYTES_W'(rd_size);
			end
			if (ctl.set_shut) begin
				shut_q <= 1'b1;
			end
			if (ctl.load_rem) begin
				rem_q <= (count_q < batch_size_q) ? count_q : batch_size_q;
			end else if (ctl.pop && mode_q == bbdq_pkg::MODE_COLLECT) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_kind_q   <= ctl.kind;
			out_reason_q <= ctl.reason;
			out_ready_q  <= ctl.ready;
			out_count_q  <= count_nxt;
			out_done_q   <= ctl.done;
			out_last_q   <= ctl.last;
			if (ctl.from_ram) begin
				out_tag_q  <= bbdq_pkg::TAG_W'(rd_tag);
				out_size_q <= rd_size;
			end else if (ctl.kind == bbdq_pkg::KIND_ACCEPTED
			             || ctl.kind == bbdq_pkg::KIND_DROPPED) begin
				out_tag_q  <= bbdq_pkg::TAG_W'(tag_q);
				out_size_q <= size_q;
			end else begin
				out_tag_q  <= '0;
				out_size_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_done_q, out_count_q, out_ready_q, out_reason_q,
	                   out_size_q, out_tag_q};

	// occupancy never passes the ring depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("queue count above ring depth");

	// an empty queue holds no bytes
	a_bytes_empty: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> bytes_q == '0)
		else $error("byte total nonzero on empty queue");

	// pops only from an occupied queue
	a_pop_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> count_q != '0)
		else $error("pop from empty queue");

	// a collect run never pops past its batch
	a_collect_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbdq_pkg::S_POP && mode_q == bbdq_pkg::MODE_COLLECT) |-> rem_q != '0)
		else $error("collect run with no records left");

	// a finished result is never overwritten before its transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !ctl.emit)
		else $error("result register overwritten while stalled");

endmodule

// ----- tb/bbdq_checker.sv -----
// result checker for the byte budget drop queue: mirrors the queue and compares every result
module bbdq_checker import bbdq_pkg::*; #(
	parameter int unsigned DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BUDGET_W-1:0]   cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // record_tag[15:0], record_size[47:16]
	input  logic [MODE_W-1:0]     s_tuser,  // mode[1:0]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_DATA_W-1:0]   m_tdata,  // tag[15:0], size[47:16], drop_reason[49:48],
	                                        // batch_ready[50], queue_count[56:51],
	                                        // done_res[57], zero[63:58]
	input  logic [KIND_W-1:0]     m_tuser,  // kind[2:0]
	input  logic                  m_tlast,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [KIND_W-1:0]   kind;
		logic [TAG_W-1:0]    tag;
		logic [SIZE_W-1:0]   size;
		logic [REASON_W-1:0] reason;
		logic                ready;
		logic [COUNT_W-1:0]  count;
		logic                drained;
		logic                last;
	} outcome_t;

	outcome_t outcome_q[$];
	int errors = 0;

	// mirrored register file
	logic [COUNT_W-1:0]  cap_records;
	logic [COUNT_W-1:0]  batch_len;
	logic [SIZE_W-1:0]   size_limit;
	logic [BUDGET_W-1:0] byte_limit;
	logic                evict_mode;

	// mirrored queue contents
	logic [TAG_W-1:0]  ring_tag [DEPTH];
	logic [SIZE_W-1:0] ring_size [DEPTH];
	int unsigned       head;
	int unsigned       fill;
	longint unsigned   bytes_held;
	logic              closed;

	assign fail_count = errors;

	// queue one expected result, stamped with the current fill level
	task automatic note(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag,
			input logic [SIZE_W-1:0] size, input logic [REASON_W-1:0] reason,
			input logic ready, input logic drained, input logic last);
		outcome_t o;
		o.kind    = kind;
		o.tag     = tag;
		o.size    = size;
		o.reason  = reason;
		o.ready   = ready;
		o.count   = COUNT_W'(fill);
		o.drained = drained;
		o.last    = last;
		outcome_q = {outcome_q, o};
	endtask

	task automatic pop_oldest(output logic [TAG_W-1:0] t, output logic [SIZE_W-1:0] sz);
		t = ring_tag[head];
		sz = ring_size[head];
		bytes_held -= sz;
		head = (head + 1) % DEPTH;
		fill--;
	endtask

	// work out every result that one input item causes
	task automatic queue_outcome(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
			input logic [SIZE_W-1:0] size);
		int unsigned cap;
		int unsigned n;
		int unsigned slot;
		logic [TAG_W-1:0] et;
		logic [SIZE_W-1:0] es;
		logic finished;
		logic drained;
		case (mode)
			MODE_ENQUEUE: begin
				cap = (cap_records < DEPTH) ? cap_records : DEPTH;
				if (closed) begin
					note(KIND_DROPPED, tag, size, REASON_SHUT, 1'b0, 1'b0, 1'b1);
				end else if (size > size_limit) begin
					note(KIND_DROPPED, tag, size, REASON_LARGE, 1'b0, 1'b0, 1'b1);
				end else begin
					finished = 1'b0;
					// make room from the head, or refuse the newcomer
					while (!finished && (fill >= cap || bytes_held + size > byte_limit)) begin
						if (!evict_mode || fill == 0) begin
							note(KIND_DROPPED, tag, size, REASON_FULL, 1'b0, 1'b0, 1'b1);
							finished = 1'b1;
						end else begin
							pop_oldest(et, es);
							note(KIND_EVICTED, et, es, REASON_FULL, 1'b0, 1'b0, 1'b0);
						end
					end
					if (!finished) begin
						slot = (head + fill) % DEPTH;
						ring_tag[slot] = tag;
						ring_size[slot] = size;
						fill++;
						bytes_held += size;
						note(KIND_ACCEPTED, tag, size, REASON_NONE, fill >= batch_len,
							1'b0, 1'b1);
					end
				end
			end
			MODE_COLLECT: begin
				n = (fill < batch_len) ? fill : batch_len;
				drained = closed && fill == n;
				if (n == 0) begin
					note(KIND_BATCH_NIL, '0, '0, REASON_NONE, 1'b0, drained, 1'b1);
				end else begin
					for (int i = 0; i < n; i++) begin
						pop_oldest(et, es);
						note(KIND_BATCH_REC, et, es, REASON_NONE, 1'b0, drained, i == n - 1);
					end
				end
			end
			MODE_SHUTDOWN: begin
				if (closed) begin
					note(KIND_WAS_SHUT, '0, '0, REASON_NONE, 1'b0, 1'b0, 1'b1);
				end else begin
					closed = 1'b1;
					note(KIND_SHUT, '0, '0, REASON_NONE, 1'b0, 1'b0, 1'b1);
				end
			end
			default: ;  // unknown mode is ignored
		endcase
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// sample all three channels at the clock edge
	always @(posedge clk) begin
		outcome_t o;
		if (!arst_n) begin
			cap_records = RST_MAX_RECORDS;
			batch_len   = RST_BATCH_SIZE;
			size_limit  = RST_MAX_REC_SZ;
			byte_limit  = RST_MAX_BYTES;
			evict_mode  = 1'b0;
			head        = 0;
			fill        = 0;
			bytes_held  = 0;
			closed      = 1'b0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_RECORDS: cap_records = cfg_data[COUNT_W-1:0];
					CFG_BATCH_SIZE:  batch_len   = cfg_data[COUNT_W-1:0];
					CFG_MAX_REC_SZ:  size_limit  = cfg_data[SIZE_W-1:0];
					CFG_MAX_BYTES:   byte_limit  = cfg_data;
					CFG_EVICT_OLD:   evict_mode  = cfg_data[0];
					default: ;
				endcase
			end
			// input transfer
			if (s_tvalid && s_tready)
				queue_outcome(s_tuser, s_tdata[15:0], s_tdata[47:16]);
			// result transfer
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					$error("unexpected result: kind %0d tag %0h size %0h",
						m_tuser, m_tdata[15:0], m_tdata[47:16]);
					errors++;
				end else begin
					o = outcome_q[0];
					outcome_q.delete(0);
					check_field("kind", 64'(o.kind), 64'(m_tuser));
					check_field("tag", 64'(o.tag), 64'(m_tdata[15:0]));
					check_field("size", 64'(o.size), 64'(m_tdata[47:16]));
					check_field("drop_reason", 64'(o.reason), 64'(m_tdata[49:48]));
					check_field("batch_ready", 64'(o.ready), 64'(m_tdata[50]));
					check_field("queue_count", 64'(o.count), 64'(m_tdata[56:51]));
					check_field("done_res", 64'(o.drained), 64'(m_tdata[57]));
					check_field("pad", 64'd0, 64'(m_tdata[63:58]));
					check_field("last", 64'(o.last), 64'(m_tlast));
				end
			end
			pending <= outcome_q.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// testbench top for the byte budget drop queue: stimulus, receiver stalls and verdict
module tb import bbdq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;
	localparam int HOLD_AFTER  = 40;
	localparam int SETTLE      = 12;
	localparam logic [BUDGET_W-1:0] BYTES_MAX = 40'hFF_FFFF_FFFF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BUDGET_W-1:0]  cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic [MODE_W-1:0]    s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic [KIND_W-1:0]    m_tuser;
	logic                 m_tlast;

	int fail_count;
	int pending;
	int taken_items = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	logic [SIZE_W-1:0] cur_size_limit = RST_MAX_REC_SZ;

	always #5 clk = ~clk;

	byte_budget_drop_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	bbdq_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// count input transfers, used to place the long receiver hold-off
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			taken_items <= taken_items + 1;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("byte_budget_drop_queue verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one input transfer, with bursts and random gaps on the sender side
	task automatic offer(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
			input logic [SIZE_W-1:0] size);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : $urandom_range(0, 4);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {size, tag};
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BUDGET_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [COUNT_W-1:0] records, input logic [COUNT_W-1:0] batch,
			input logic [SIZE_W-1:0] rec_limit, input logic [BUDGET_W-1:0] bytes,
			input logic evict);
		write_reg(CFG_MAX_RECORDS, BUDGET_W'(records));
		write_reg(CFG_BATCH_SIZE, BUDGET_W'(batch));
		write_reg(CFG_MAX_REC_SZ, BUDGET_W'(rec_limit));
		write_reg(CFG_MAX_BYTES, bytes);
		write_reg(CFG_EVICT_OLD, BUDGET_W'(evict));
		cfg_valid <= 1'b0;
		cur_size_limit = rec_limit;
	endtask

	// stop sending and let every expected result drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return cur_size_limit;
			3: return cur_size_limit + 1;
			4: return $urandom();
			default: return $urandom_range(0, 3000);
		endcase
	endfunction

	// random mix of enqueues and collects, with a little ignored-mode noise
	task automatic run_phase(input int count, input int collect_pct);
		int sent;
		int pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				offer(MODE_IGNORED, 16'($urandom()), $urandom());
			end else if (pick < 5 + collect_pct) begin
				offer(MODE_COLLECT, 16'($urandom()), $urandom());
				sent++;
			end else begin
				offer(MODE_ENQUEUE, 16'($urandom()), pick_size());
				sent++;
			end
		end
	endtask

	// receiver: segments of different stall patterns, one long hold-off
	initial begin
		int seg_kind;
		int seg_len;
		int period;
		bit held;
		held = 1'b0;
		forever begin
			seg_kind = $urandom_range(0, 3);
			seg_len  = $urandom_range(10, 80);
			period   = $urandom_range(2, 5);
			for (int c = 0; c < seg_len; c++) begin
				if (!held && taken_items >= HOLD_AFTER) begin
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					held = 1'b1;
				end
				case (seg_kind)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= (c % period == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: field extremes, size limit edge, ignored mode, collect and empty collect
		offer(MODE_ENQUEUE, 16'h0000, 32'd0);
		offer(MODE_ENQUEUE, 16'hFFFF, 32'd65536);
		offer(MODE_ENQUEUE, 16'h1234, 32'd65537);
		offer(MODE_ENQUEUE, 16'hA5A5, 32'hFFFF_FFFF);
		offer(MODE_IGNORED, 16'hFFFF, 32'hFFFF_FFFF);
		offer(MODE_COLLECT, 16'h0000, 32'd0);
		offer(MODE_COLLECT, 16'h0000, 32'd0);

		// drop newest on count cap, zero batch size
		wait_idle();
		set_config(6'd2, 6'd0, '1, BYTES_MAX, 1'b0);
		offer(MODE_ENQUEUE, 16'd1, 32'd10);
		offer(MODE_ENQUEUE, 16'd2, 32'd20);
		offer(MODE_ENQUEUE, 16'd3, 32'd30);
		offer(MODE_COLLECT, 16'd0, 32'd0);

		// evict oldest on count cap and on byte budget, then a record that never fits
		wait_idle();
		set_config(6'd2, 6'd32, '1, 40'd100, 1'b1);
		offer(MODE_ENQUEUE, 16'd4, 32'd40);
		offer(MODE_ENQUEUE, 16'd5, 32'd90);
		offer(MODE_ENQUEUE, 16'd6, 32'd200);
		offer(MODE_ENQUEUE, 16'd7, 32'd50);

		// zero count cap: evict everything, then refuse
		wait_idle();
		set_config(6'd0, 6'd32, '1, 40'd100, 1'b1);
		offer(MODE_ENQUEUE, 16'd8, 32'd5);
		offer(MODE_ENQUEUE, 16'd9, 32'd0);

		// random phases over several settings
		wait_idle();
		set_config(6'd63, 6'd8, 32'd65536, BYTES_MAX, 1'b0);
		run_phase(75, 10);
		wait_idle();
		set_config(6'd63, 6'd32, '1, 40'd40000, 1'b1);
		run_phase(75, 20);
		wait_idle();
		set_config(6'd1, 6'd1, 32'd3000, BYTES_MAX, 1'b1);
		run_phase(75, 40);
		wait_idle();
		set_config(6'($urandom_range(2, 31)), 6'($urandom_range(0, 40)),
			SIZE_W'($urandom_range(500, 8000)), BUDGET_W'($urandom_range(2000, 20000)),
			1'($urandom_range(0, 1)));
		run_phase(75, 25);
		wait_idle();
		set_config(6'd0, 6'd5, 32'd0, 40'd0, 1'b0);
		run_phase(40, 30);
		wait_idle();
		set_config(6'd32, 6'd63, 32'd65536, RST_MAX_BYTES, 1'b1);
		run_phase(40, 15);

		// shutdown: refused enqueues, repeated shutdown, draining collects
		wait_idle();
		set_config(6'd32, 6'd4, 32'd65536, BYTES_MAX, 1'b0);
		for (int i = 0; i < 6; i++)
			offer(MODE_ENQUEUE, 16'($urandom()), $urandom_range(0, 3000));
		offer(MODE_SHUTDOWN, 16'h0000, 32'd0);
		offer(MODE_SHUTDOWN, 16'hFFFF, 32'hFFFF_FFFF);
		offer(MODE_ENQUEUE, 16'h5A5A, 32'd100);
		offer(MODE_ENQUEUE, 16'h5A5B, 32'hFFFF_FFFF);
		offer(MODE_COLLECT, 16'h0000, 32'd0);
		offer(MODE_COLLECT, 16'h0000, 32'd0);
		offer(MODE_COLLECT, 16'h0000, 32'd0);

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("byte_budget_drop_queue verification clean");
		end else begin
			$display("byte_budget_drop_queue verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/bbdq_pkg.sv
hw/rtl/bbdq_ram.sv
hw/rtl/byte_budget_drop_queue.sv
tb/bbdq_checker.sv
tb/tb.sv
